### hw/rtl/sha_pkg.sv
// SHA-256 core package: round constants, initial hash, round functions and command types.
`default_nettype none

package sha_pkg;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] PAD_STOP   = 6'd55;  // byte before the length field
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;
  localparam logic [2:0] BYTES_MAX  = 3'd4;

  typedef logic [7:0][31:0] hash_t;

  typedef struct packed {
    logic       wr_byte;
    logic [5:0] pos;
    logic [7:0] value;
    logic       wr_len;
    logic       shift;
  } sched_cmd_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       fold;
    logic       init;
    logic [5:0] rnd;
  } round_cmd_t;

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

### hw/rtl/sha_if.sv
// Valid/ready channels of the SHA-256 core: message words in, digest words out.
`default_nettype none

interface sha_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        end_of_message;

  modport source(output valid, data_word, byte_count, end_of_message, input ready);
  modport sink(input valid, data_word, byte_count, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source(output valid, digest_word, word_index, last_word, input ready);
  modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

### hw/rtl/sha_sched.sv
// Block buffer that doubles as the 16-word message schedule window.
`default_nettype none

module sha_sched
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire sched_cmd_t  cmd,
  input  wire logic [63:0] len_bits,
  output      logic [31:0] w_cur
);

  logic [31:0] win [16];
  logic [31:0] w_new;
  logic [3:0]  widx;
  logic [1:0]  lane;

  assign widx  = cmd.pos[5:2];
  assign lane  = cmd.pos[1:0];
  assign w_cur = win[0];
  assign w_new = ssig1(win[14]) + win[9] + ssig0(win[1]) + win[0];

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w_new;
    end else if (cmd.wr_len) begin
      win[14] <= len_bits[63:32];
      win[15] <= len_bits[31:0];
    end else if (cmd.wr_byte) begin
      case (lane)
        2'd0:    win[widx] <= {cmd.value, 24'h0};
        2'd1:    win[widx][23:16] <= cmd.value;
        2'd2:    win[widx][15:8] <= cmd.value;
        default: win[widx][7:0] <= cmd.value;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sha_round.sv
// Working variables, chaining hash and the shared one-round compression unit.
`default_nettype none

module sha_round
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire round_cmd_t  cmd,
  input  wire logic [31:0] w_cur,
  output      hash_t       hash
);

  hash_t       v;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  assign ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1  = v[7] + bsig1(v[4]) + ch + ROUND_K[cmd.rnd] + w_cur;
  assign t2  = bsig0(v[0]) + maj;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v <= hash;
    end else if (cmd.step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= HASH_INIT[i];
      end
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= hash[i] + v[i];
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sha256_hash_core_unit.sv
// Streaming SHA-256 core top level: byte packer, padding and round sequencer.
//
//   channel  dir  beat
//   msg      in   data_word[31:0], byte_count[2:0], end_of_message
//   dig      out  digest_word[31:0], word_index[2:0], last_word
//
// Message bytes go into the block buffer one byte per cycle, held while a full block is compressed.
// Each full 64-byte block runs 64 rounds of the shared round unit and then a fold.
// End of message writes the pad bytes and the length, compresses each padded block, then
// sends eight digest beats. msg.ready drops on accept and returns once the word is packed,
// or for a final word once the last digest beat is taken.
// Synchronous reset loads the initial hash and clears the fill and length counts.
`default_nettype none

module sha256_hash_core_unit
  import sha_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  sha_in_if.sink   msg,
  sha_out_if.source dig
);

  typedef enum logic [2:0] {
    IDLE, BYTES, PAD, LEN, COMP, FOLD, OUT
  } state_t;

  state_t      state;
  state_t      ret;
  logic [31:0] data;
  logic [2:0]  cnt;
  logic        last;
  logic [2:0]  bidx;
  logic [5:0]  fill;
  logic [60:0] msg_len;
  logic [5:0]  rnd;
  logic        pad_first;
  logic [2:0]  out_idx;

  sched_cmd_t  scmd;
  round_cmd_t  rcmd;
  logic [31:0] w_cur;
  hash_t       hash;
  logic [7:0]  sel_byte;
  logic [2:0]  cnt_in;
  logic        byte_wr;

  assign cnt_in  = (msg.byte_count > BYTES_MAX) ? BYTES_MAX : msg.byte_count;
  assign byte_wr = (state == BYTES && bidx != cnt) || state == PAD;

  always_comb begin
    case (bidx[1:0])
      2'd0:    sel_byte = data[31:24];
      2'd1:    sel_byte = data[23:16];
      2'd2:    sel_byte = data[15:8];
      default: sel_byte = data[7:0];
    endcase
  end

  always_comb begin
    scmd.wr_byte = byte_wr;
    scmd.pos     = fill;
    scmd.value   = (state == PAD) ? (pad_first ? PAD_BYTE : 8'h00) : sel_byte;
    scmd.wr_len  = (state == LEN);
    scmd.shift   = (state == COMP);
    rcmd.load    = (byte_wr && fill == FILL_LAST) || state == LEN;
    rcmd.step    = (state == COMP);
    rcmd.fold    = (state == FOLD);
    rcmd.init    = (state == OUT) && dig.ready && out_idx == WORD_LAST;
    rcmd.rnd     = rnd;
  end

  sha_sched u_sched (
    .clk      (clk),
    .cmd      (scmd),
    .len_bits ({msg_len, 3'b000}),
    .w_cur    (w_cur)
  );

  sha_round u_round (
    .clk   (clk),
    .rst   (rst),
    .cmd   (rcmd),
    .w_cur (w_cur),
    .hash  (hash)
  );

  assign msg.ready       = (state == IDLE);
  assign dig.valid       = (state == OUT);
  assign dig.digest_word = hash[out_idx];
  assign dig.word_index  = out_idx;
  assign dig.last_word   = (out_idx == WORD_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      ret       <= IDLE;
      bidx      <= 3'd0;
      fill      <= 6'd0;
      msg_len   <= 61'd0;
      rnd       <= 6'd0;
      pad_first <= 1'b0;
      out_idx   <= 3'd0;
    end else begin
      unique case (state)
        IDLE: begin
          if (msg.valid) begin
            data    <= msg.data_word;
            cnt     <= cnt_in;
            last    <= msg.end_of_message;
            bidx    <= 3'd0;
            msg_len <= msg_len + {58'd0, cnt_in};
            state   <= BYTES;
          end
        end
        BYTES: begin
          if (bidx == cnt) begin
            if (last) begin
              pad_first <= 1'b1;
              state     <= PAD;
            end else begin
              state <= IDLE;
            end
          end else begin
            bidx <= bidx + 3'd1;
            fill <= fill + 6'd1;
            if (fill == FILL_LAST) begin
              rnd   <= 6'd0;
              ret   <= BYTES;
              state <= COMP;
            end
          end
        end
        PAD: begin
          pad_first <= 1'b0;
          fill      <= fill + 6'd1;
          if (fill == FILL_LAST) begin
            rnd   <= 6'd0;
            ret   <= PAD;
            state <= COMP;
          end else if (fill == PAD_STOP) begin
            state <= LEN;
          end
        end
        LEN: begin
          rnd     <= 6'd0;
          ret     <= OUT;
          out_idx <= 3'd0;
          state   <= COMP;
        end
        COMP: begin
          rnd <= rnd + 6'd1;
          if (rnd == ROUND_LAST) begin
            state <= FOLD;
          end
        end
        FOLD: begin
          state <= ret;
        end
        OUT: begin
          if (dig.ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == WORD_LAST) begin
              fill    <= 6'd0;
              msg_len <= 61'd0;
              state   <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
